>>> rtl/core/ius2x_pkg.sv
// ----------------------------------------------------------------------------
// ius2x_pkg: shared types and constants of the 2x averaging upscaler
// Pixel type, averaging helper, register codes and the job word that passes
// from the row-store stage to the output sequencer.
// ----------------------------------------------------------------------------
package ius2x_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;
	localparam int CH_W           = 8;
	localparam int DIM_W          = 12;
	localparam int COORD_W        = 12;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 4'd0,
		REG_SOURCE_HEIGHT = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pixel_t;

	// e0: mean of left and current; o0: odd-row value of the in-between column;
	// o1: odd-row value of the current column
	typedef struct packed {
		pixel_t e0;
		pixel_t cur;
		pixel_t o0;
		pixel_t o1;
		logic   has_left;
		logic   has_up;
		logic   last_col;
		logic   last_row;
	} job_t;

	function automatic pixel_t mean2(pixel_t a, pixel_t b);
		logic [CH_W:0] sb;
		logic [CH_W:0] sg;
		logic [CH_W:0] sr;
		pixel_t        m;
		sb = {1'b0, a.blue} + {1'b0, b.blue};
		sg = {1'b0, a.green} + {1'b0, b.green};
		sr = {1'b0, a.red} + {1'b0, b.red};
		m.blue  = sb[CH_W:1];
		m.green = sg[CH_W:1];
		m.red   = sr[CH_W:1];
		return m;
	endfunction

endpackage

>>> rtl/core/ius2x_if.sv
// ----------------------------------------------------------------------------
// ius2x_if: stream channels of the 2x averaging upscaler
// Source pixel channel and upscaled pixel channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ius2x_in_if;
	logic                       valid;
	logic                       ready;
	logic [ius2x_pkg::CH_W-1:0] blue_in;
	logic [ius2x_pkg::CH_W-1:0] green_in;
	logic [ius2x_pkg::CH_W-1:0] red_in;

	modport source (output valid, output blue_in, output green_in, output red_in,
		input ready);
	modport sink (input valid, input blue_in, input green_in, input red_in,
		output ready);
endinterface

interface ius2x_out_if;
	logic                          valid;
	logic                          ready;
	logic [ius2x_pkg::CH_W-1:0]    blue_out;
	logic [ius2x_pkg::CH_W-1:0]    green_out;
	logic [ius2x_pkg::CH_W-1:0]    red_out;
	logic [ius2x_pkg::COORD_W-1:0] out_x;
	logic [ius2x_pkg::COORD_W-1:0] out_y;
	logic                          last_of_run;
	logic                          frame_done;

	modport source (output valid, output blue_out, output green_out, output red_out,
		output out_x, output out_y, output last_of_run, output frame_done,
		input ready);
	modport sink (input valid, input blue_out, input green_out, input red_out,
		input out_x, input out_y, input last_of_run, input frame_done,
		output ready);
endinterface

>>> rtl/core/ius2x_emit.sv
// ----------------------------------------------------------------------------
// ius2x_emit: output sequencer
// Walks the up to 3x3 output positions of one job, one word per unstalled
// cycle, into an output register; takes the next job as its last word leaves.
// ----------------------------------------------------------------------------
module ius2x_emit #(
	parameter int MAX_WIDTH  = ius2x_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ius2x_pkg::MAX_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  ius2x_pkg::job_t               job,
	input  logic [$clog2(MAX_WIDTH)-1:0]  job_col,
	input  logic [$clog2(MAX_HEIGHT)-1:0] job_row,
	ius2x_out_if.source                   out_ch
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int XW = CW + 1;
	localparam int YW = RW + 1;

	logic                             s2_valid_q;
	ius2x_pkg::job_t                  job_s2;
	logic [CW-1:0]                    c_s2;
	logic [RW-1:0]                    r_s2;
	logic [1:0]                       i_q;
	logic [1:0]                       j_q;
	logic [1:0]                       j_start;
	logic [1:0]                       j_end;
	logic [1:0]                       i_end;
	logic                             row_end;
	logic                             word_last;
	logic                             emit;
	ius2x_pkg::pixel_t                pix;
	logic [XW-1:0]                    x_full;
	logic [YW-1:0]                    y_full;

	logic                             out_valid_q;
	ius2x_pkg::pixel_t                pix_q;
	logic [ius2x_pkg::COORD_W-1:0]    x_q;
	logic [ius2x_pkg::COORD_W-1:0]    y_q;
	logic                             last_q;
	logic                             done_q;

	assign j_start   = job_s2.has_left ? 2'd0 : 2'd1;
	assign j_end     = job_s2.last_col ? 2'd2 : 2'd1;
	assign i_end     = job_s2.last_row ? 2'd2 : 2'd1;
	assign row_end   = (j_q == j_end);
	assign word_last = row_end && (i_q == i_end);
	assign emit      = s2_valid_q && (!out_valid_q || out_ch.ready);
	assign job_ready = !s2_valid_q || (emit && word_last);

	always_comb begin
		if (i_q == 2'd0) begin
			pix = (j_q == 2'd0) ? job_s2.o0 : job_s2.o1;
		end else begin
			pix = (j_q == 2'd0) ? job_s2.e0 : job_s2.cur;
		end
		x_full = {c_s2, 1'b0} + XW'(j_q) - XW'(1);
		y_full = {r_s2, 1'b0} + YW'(i_q) - YW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			i_q        <= 2'd0;
			j_q        <= 2'd0;
		end else if (job_ready) begin
			s2_valid_q <= job_valid;
			i_q        <= job.has_up ? 2'd0 : 2'd1;
			j_q        <= job.has_left ? 2'd0 : 2'd1;
		end else if (emit) begin
			if (row_end) begin
				j_q <= j_start;
				i_q <= i_q + 2'd1;
			end else begin
				j_q <= j_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			job_s2 <= job;
			c_s2   <= job_col;
			r_s2   <= job_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_q  <= pix;
			x_q    <= ius2x_pkg::COORD_W'(x_full);
			y_q    <= ius2x_pkg::COORD_W'(y_full);
			last_q <= word_last;
			done_q <= word_last && job_s2.last_col && job_s2.last_row;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.blue_out    = pix_q.blue;
	assign out_ch.green_out   = pix_q.green;
	assign out_ch.red_out     = pix_q.red;
	assign out_ch.out_x       = x_q;
	assign out_ch.out_y       = y_q;
	assign out_ch.last_of_run = last_q;
	assign out_ch.frame_done  = done_q;

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q |-> (i_q <= i_end && j_q <= j_end))
		else $error("sequencer position past end of job");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready && s2_valid_q |=> s2_valid_q && $stable(i_q)
			&& $stable(j_q))
		else $error("sequencer advanced while output stalled");

	a_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(pix_q) && $stable(x_q)
			&& $stable(y_q) && $stable(last_q) && $stable(done_q))
		else $error("output word changed while stalled");
`endif

endmodule

>>> rtl/core/image_upscale_2x_average.sv
// ----------------------------------------------------------------------------
// image_upscale_2x_average: streaming 2x upscaler with averaged fill pixels
// Source RGB pixels in raster order in, twice-size image with coordinates out.
// ----------------------------------------------------------------------------
// cfg_we/cfg_index/cfg_data write source_width (0) and source_height (1); any
// write to those restarts the frame. Write only while the block is idle.
// in_ch takes one source pixel per word. out_ch gives the 1 to 9 output pixels
// that pixel completes, row by row, each with out_x/out_y; last_of_run marks
// the last word of a source pixel, frame_done the last word of the frame.
// Pixels pass the row-store stage, the sequencer and the output register;
// one word leaves per cycle unless out_ch stalls (4 per inner pixel);
// the next pixel is read from the row store while the current one is emitted.
// arst_n clears control and sets both dimensions to 1. The row store needs no
// clearing; it is always written on the first row before being read.
// If out_ch.ready is low the output word holds, the sequencer stops and
// in_ch.ready drops once the row-store stage is full.
// ----------------------------------------------------------------------------
module image_upscale_2x_average #(
	parameter int MAX_WIDTH  = ius2x_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ius2x_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ius2x_in_if.sink                           in_ch,
	ius2x_out_if.source                        out_ch,
	input  logic                               cfg_we,
	input  logic [ius2x_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ius2x_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0]                  w_last_q;
	logic [RW-1:0]                  h_last_q;
	logic [CW-1:0]                  w_last_d;
	logic [RW-1:0]                  h_last_d;
	logic [ius2x_pkg::DIM_W-1:0]    dim_raw;
	logic [CW-1:0]                  col_q;
	logic [RW-1:0]                  row_q;
	logic                           in_acc;

	logic                           s1_valid_q;
	ius2x_pkg::pixel_t              cur_s1;
	logic [CW-1:0]                  c_s1;
	logic [RW-1:0]                  r_s1;
	logic                           has_left_s1;
	logic                           has_up_s1;
	logic                           last_col_s1;
	logic                           last_row_s1;
	logic                           fwd_s1;
	ius2x_pkg::pixel_t              fwd_pix_s1;
	ius2x_pkg::pixel_t              rd_s1;
	logic                           s1_adv;
	logic                           job_ready;

	ius2x_pkg::pixel_t              row_mem [MAX_WIDTH];
	ius2x_pkg::pixel_t              left_q;
	ius2x_pkg::pixel_t              ul_q;
	ius2x_pkg::pixel_t              up;
	ius2x_pkg::pixel_t              cur_in;
	ius2x_pkg::job_t                job;

	assign dim_raw = cfg_data[ius2x_pkg::DIM_W-1:0];

	always_comb begin
		if (dim_raw == '0) begin
			w_last_d = '0;
		end else if (32'(dim_raw) > MAX_WIDTH) begin
			w_last_d = CW'(MAX_WIDTH - 1);
		end else begin
			w_last_d = CW'(dim_raw - 1'b1);
		end
		if (dim_raw == '0) begin
			h_last_d = '0;
		end else if (32'(dim_raw) > MAX_HEIGHT) begin
			h_last_d = RW'(MAX_HEIGHT - 1);
		end else begin
			h_last_d = RW'(dim_raw - 1'b1);
		end
	end

	assign in_acc      = in_ch.valid && in_ch.ready;
	assign s1_adv      = s1_valid_q && job_ready;
	assign in_ch.ready = !s1_valid_q || job_ready;
	assign cur_in      = '{blue: in_ch.blue_in, green: in_ch.green_in, red: in_ch.red_in};

	// dimensions and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= '0;
			h_last_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ius2x_pkg::REG_SOURCE_WIDTH: begin
					w_last_q <= w_last_d;
					col_q    <= '0;
					row_q    <= '0;
				end
				ius2x_pkg::REG_SOURCE_HEIGHT: begin
					h_last_q <= h_last_d;
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (in_acc) begin
			if (col_q == w_last_q) begin
				col_q <= '0;
				row_q <= (row_q == h_last_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// same-entry write in the accept cycle only happens for one-pixel rows
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_s1      <= cur_in;
			c_s1        <= col_q;
			r_s1        <= row_q;
			has_left_s1 <= (col_q != '0);
			has_up_s1   <= (row_q != '0);
			last_col_s1 <= (col_q == w_last_q);
			last_row_s1 <= (row_q == h_last_q);
			fwd_s1      <= s1_adv && (c_s1 == col_q);
			fwd_pix_s1  <= cur_s1;
		end
	end

	// row store: read at accept, write back as the pixel leaves stage 1
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			row_mem[c_s1] <= cur_s1;
		end
		if (in_acc) begin
			rd_s1 <= row_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			left_q <= cur_s1;
			ul_q   <= up;
		end
	end

	always_comb begin
		up           = fwd_s1 ? fwd_pix_s1 : rd_s1;
		job.e0       = ius2x_pkg::mean2(left_q, cur_s1);
		job.cur      = cur_s1;
		job.o0       = ius2x_pkg::mean2(ius2x_pkg::mean2(ul_q, up), job.e0);
		job.o1       = ius2x_pkg::mean2(up, cur_s1);
		job.has_left = has_left_s1;
		job.has_up   = has_up_s1;
		job.last_col = last_col_s1;
		job.last_row = last_row_s1;
	end

	ius2x_emit #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (s1_valid_q),
		.job_ready (job_ready),
		.job       (job),
		.job_col   (c_s1),
		.job_row   (r_s1),
		.out_ch    (out_ch)
	);

`ifndef ASSERT_OFF
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= w_last_q)
		else $error("column counter past row width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_last_q)
		else $error("row counter past image height");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !job_ready |=> s1_valid_q && $stable(cur_s1) && $stable(c_s1))
		else $error("stage 1 word lost while sequencer busy");
`endif

endmodule
